// File: rtl/ccpg_pkg.sv
// ----------------------------------------------------------------------------
// Clipped circle point generator package
// Shared widths, codes, the job record passed from the walker to the emitter,
// and the bounds check used when culling reflections.
// ----------------------------------------------------------------------------
package ccpg_pkg;

  // Coordinate width; the image registers carry one extra bit.
  localparam int COORD_BITS = 12;
  localparam int REG_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 5;
  localparam int NUM_REFL   = 8;
  localparam int REFL_BITS  = $clog2(NUM_REFL);

  // Decision value constants of the midpoint walk.
  localparam int DEC_INIT      = 3;
  localparam int DEC_INC_AXIAL = 6;
  localparam int DEC_INC_DIAG  = 10;

  // Reset value of both image registers.
  localparam logic [REG_BITS-1:0] IMAGE_RESET = REG_BITS'(1 << COORD_BITS);

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [REG_BITS-1:0]      ext_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Request kinds on the input channel.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  // One unit of work for the emitter: the octant point about a centre.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t x;
    coord_t y;
    logic   done;
    logic   empty;   // status-only request, no reflections at all
  } job_t;

  // True when a coordinate (with carry or borrow bit) lies inside the image.
  function automatic logic in_bounds(ext_t v, ext_t lim);
    in_bounds = !v[COORD_BITS] && (v < lim);
  endfunction

endpackage

// File: rtl/ccpg_walker.sv
// ----------------------------------------------------------------------------
// Circle walker
// Holds the octant walk state, applies one start or step request per accepted
// input, and hands the resulting octant point to the emitter as a job.
// ----------------------------------------------------------------------------
module ccpg_walker
  import ccpg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  mode_t  mode,
  input  coord_t center_x,
  input  coord_t center_y,
  input  coord_t radius,
  output logic   job_valid,
  output job_t   job,
  input  logic   job_take
);

  coord_t octant_x, octant_x_next;
  coord_t octant_y, octant_y_next;
  dec_t   decision, decision_next;
  coord_t centre_x_held, centre_x_held_next;
  coord_t centre_y_held, centre_y_held_next;
  logic   walk_finished, walk_finished_next;
  logic   step_idle;
  logic   accept;
  dec_t   x_ext, y_ext, r_ext;

  assign in_ready = !job_valid || job_take;
  assign accept   = in_valid && in_ready;

  assign x_ext = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, octant_x});
  assign y_ext = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, octant_y});
  assign r_ext = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, radius});

  // Next walk state for the request at the input.
  always_comb begin
    octant_x_next      = octant_x;
    octant_y_next      = octant_y;
    decision_next      = decision;
    centre_x_held_next = centre_x_held;
    centre_y_held_next = centre_y_held;
    step_idle          = 1'b0;
    if (mode == MODE_START) begin
      centre_x_held_next = center_x;
      centre_y_held_next = center_y;
      octant_x_next      = '0;
      octant_y_next      = radius;
      decision_next      = dec_t'(DEC_INIT) - (r_ext <<< 1);
    end else if (walk_finished) begin
      // A step after the walk ended leaves the state alone.
      step_idle = 1'b1;
    end else if (decision[DEC_BITS-1] || (decision == '0)) begin
      decision_next = decision + (x_ext <<< 2) + dec_t'(DEC_INC_AXIAL);
      octant_x_next = octant_x + coord_t'(1);
    end else begin
      decision_next = decision + ((x_ext - y_ext) <<< 2) + dec_t'(DEC_INC_DIAG);
      octant_x_next = octant_x + coord_t'(1);
      octant_y_next = octant_y - coord_t'(1);
    end
    walk_finished_next = !(octant_x_next < octant_y_next);
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      octant_x      <= '0;
      octant_y      <= '0;
      decision      <= '0;
      centre_x_held <= '0;
      centre_y_held <= '0;
      walk_finished <= 1'b1;
    end else if (accept) begin
      octant_x      <= octant_x_next;
      octant_y      <= octant_y_next;
      decision      <= decision_next;
      centre_x_held <= centre_x_held_next;
      centre_y_held <= centre_y_held_next;
      walk_finished <= walk_finished_next;
    end
  end

  // Job register toward the emitter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= accept || (job_valid && !job_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.cx    <= centre_x_held_next;
      job.cy    <= centre_y_held_next;
      job.x     <= octant_x_next;
      job.y     <= octant_y_next;
      job.done  <= walk_finished_next;
      job.empty <= step_idle;
    end
  end

`ifndef SYNTHESIS
  a_zero_radius_done: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_START) && (radius == '0) |=> walk_finished)
    else $error("start with zero radius left the walk open");

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |=> job_valid && $stable(job))
    else $error("pending job changed before the emitter took it");

  a_finished_step_still: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_STEP) && walk_finished
      |=> walk_finished && $stable(octant_x) && $stable(octant_y) && job.empty)
    else $error("step after finish moved the walk");
`endif

endmodule

// File: rtl/ccpg_emitter.sv
// ----------------------------------------------------------------------------
// Reflection emitter
// Takes a job, forms its eight reflections and keep mask, sends kept points
// (or one status item) via the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ccpg_emitter
  import ccpg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ext_t   image_width,
  input  ext_t   image_height,
  input  logic   job_valid,
  input  job_t   job,
  output logic   job_take,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t point_x,
  output coord_t point_y,
  output logic   point_valid,
  output logic   last,
  output logic   done_res
);

  coord_t                cand_x [NUM_REFL];
  coord_t                cand_y [NUM_REFL];
  logic   [NUM_REFL-1:0] mask;
  logic                  status_pend;
  logic                  job_done;

  ext_t                  new_x [NUM_REFL];
  ext_t                  new_y [NUM_REFL];
  logic   [NUM_REFL-1:0] new_mask;
  ext_t                  cx_e, cy_e, x_e, y_e;

  logic [REFL_BITS-1:0]  sel;
  logic [NUM_REFL-1:0]   remaining;
  logic                  can_out;
  logic                  active;
  logic                  emit;
  logic                  emit_last;

  // Eight reflections of the job point, with carry/borrow kept for culling.
  assign cx_e = {1'b0, job.cx};
  assign cy_e = {1'b0, job.cy};
  assign x_e  = {1'b0, job.x};
  assign y_e  = {1'b0, job.y};

  always_comb begin
    new_x[0] = cx_e + x_e;  new_y[0] = cy_e + y_e;
    new_x[1] = cx_e - x_e;  new_y[1] = cy_e + y_e;
    new_x[2] = cx_e + x_e;  new_y[2] = cy_e - y_e;
    new_x[3] = cx_e - x_e;  new_y[3] = cy_e - y_e;
    new_x[4] = cx_e + y_e;  new_y[4] = cy_e + x_e;
    new_x[5] = cx_e + y_e;  new_y[5] = cy_e - x_e;
    new_x[6] = cx_e - y_e;  new_y[6] = cy_e + x_e;
    new_x[7] = cx_e - y_e;  new_y[7] = cy_e - x_e;
    for (int i = 0; i < NUM_REFL; i++) begin
      new_mask[i] = !job.empty && in_bounds(new_x[i], image_width)
                    && in_bounds(new_y[i], image_height);
    end
  end

  // Lowest pending reflection goes out first.
  always_comb begin
    sel = '0;
    for (int i = NUM_REFL - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = REFL_BITS'(i);
      end
    end
    remaining      = mask;
    remaining[sel] = 1'b0;
  end

  assign can_out   = !out_valid || out_ready;
  assign active    = (mask != '0) || status_pend;
  assign emit      = can_out && active;
  assign emit_last = status_pend || (remaining == '0);
  assign job_take  = job_valid && (!active || (emit && emit_last));

  // Pending mask and status flag; a new job overrides the last emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= '0;
      status_pend <= 1'b0;
    end else if (job_take) begin
      mask        <= new_mask;
      status_pend <= (new_mask == '0);
    end else if (emit) begin
      if (status_pend) begin
        status_pend <= 1'b0;
      end else begin
        mask <= remaining;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_done <= job.done;
      for (int i = 0; i < NUM_REFL; i++) begin
        cand_x[i] <= new_x[i][COORD_BITS-1:0];
        cand_y[i] <= new_y[i][COORD_BITS-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_out) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last     <= emit_last;
      done_res <= job_done;
      if (status_pend) begin
        point_x     <= '0;
        point_y     <= '0;
        point_valid <= 1'b0;
      end else begin
        point_x     <= cand_x[sel];
        point_y     <= cand_y[sel];
        point_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> last)
    else $error("status-only result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> (point_x == '0) && (point_y == '0))
    else $error("status-only result carries a coordinate");

  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    status_pend |-> (mask == '0))
    else $error("status item pending alongside kept points");
`endif

endmodule

// File: rtl/clipped_circle_point_generator.sv
// ----------------------------------------------------------------------------
// Clipped circle point generator
// Midpoint circle walk whose eight reflections are culled to the image.
//   Input stream: tuser = 0 starts a circle (centre and radius in tdata),
//   tuser = 1 advances the walk one step. Each request yields the kept
//   reflections of the octant point on the output stream, one per cycle when not stalled,
//   in the fixed reflection order; tlast marks the request's final result.
//   When nothing survives culling, one status result with the valid flag
//   low is sent. The done flag rides on every result of a request.
//   With the emitter idle, an accepted request passes the walker's job register,
//   the emitter's pending mask and status flag, and the output register before m_tvalid rises.
//   A request yields at most eight results, one per cycle unless stalled; the next
//   request is taken while the current one's results drain, so they stream without gaps.
//   Image width and height are written on the configuration port while idle;
//   both reset to 4096. Reset also leaves the walk finished, so steps before
//   the first start return a status result with done set.
//   A stalled receiver holds the output register; the emitter and the job
//   register behind it fill, and then tready drops on the input side.
// ----------------------------------------------------------------------------
module clipped_circle_point_generator
  import ccpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // center_x [11:0], center_y [23:12], radius [35:24]
  input  logic        s_tuser,   // mode [0]
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // point_x [11:0], point_y [23:12]
  output logic [1:0]  m_tuser,   // point_valid [0], done_res [1]
  output logic        m_tlast,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  ext_t   image_width;
  ext_t   image_height;
  logic   job_valid;
  job_t   job;
  logic   job_take;
  coord_t point_x;
  coord_t point_y;
  logic   point_valid;
  logic   done_res;

  // Image size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_RESET;
      image_height <= IMAGE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ccpg_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (mode_t'(s_tuser)),
    .center_x  (s_tdata[11:0]),
    .center_y  (s_tdata[23:12]),
    .radius    (s_tdata[35:24]),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  ccpg_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_valid  (point_valid),
    .last         (m_tlast),
    .done_res     (done_res)
  );

  assign m_tdata = {point_y, point_x};
  assign m_tuser = {done_res, point_valid};

endmodule
